// File: rtl/edc_pkg.sv
// Shared types and constants for the elevator dispatch controller.
// No dependencies; used by edc_if, edc_ctrl, edc_dp and the top level.
package edc_pkg;

    localparam int FLOOR_W  = 3;
    localparam int KIND_W   = 3;
    localparam int STATUS_W = 2;
    localparam int CNT_W    = 4;
    localparam int DIR_W    = 2;
    localparam int LOAD_W   = 8;
    localparam int WAIT_W   = 7;
    localparam int SERV_W   = 32;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 8;
    localparam int MAXR_W   = 4;

    // opcodes
    localparam logic OP_REQUEST = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // status codes
    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_INVALID = 2'd1;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

    // move directions
    localparam logic [DIR_W-1:0] DIR_NONE = 2'b00;
    localparam logic [DIR_W-1:0] DIR_UP   = 2'b01;
    localparam logic [DIR_W-1:0] DIR_DOWN = 2'b11;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LOAD   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_RIDERS = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND0_WT   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND1_WT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND2_WT   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_KIND3_WT   = 3'd5;

    // configuration reset values
    localparam logic [LOAD_W-1:0] RST_MAX_LOAD   = 8'd50;
    localparam logic [MAXR_W-1:0] RST_MAX_RIDERS = 4'd5;
    localparam logic [LOAD_W-1:0] RST_KIND0_WT   = 8'd3;
    localparam logic [LOAD_W-1:0] RST_KIND1_WT   = 8'd14;
    localparam logic [LOAD_W-1:0] RST_KIND2_WT   = 8'd10;
    localparam logic [LOAD_W-1:0] RST_KIND3_WT   = 8'd16;

    // controller to datapath
    typedef struct packed {
        logic latch;        // capture input request
        logic req;          // enqueue / reject a passenger request
        logic alight_step;  // examine one rider slot
        logic alight_end;   // commit compacted rider count
        logic pick;         // target = nearest waiting floor
        logic rider_target; // target = first rider's destination
        logic board_take;   // board the waiter at the queue head
        logic move;         // step one floor toward target
        logic out_load;     // load the result register
    } t_cmd;

    // datapath to controller
    typedef struct packed {
        logic op;
        logic has_riders;
        logic alight_done;
        logic alight_nz;
        logic has_best;
        logic best_here;
        logic board_can;
        logic board_fit;
    } t_sts;

endpackage

// File: rtl/edc_if.sv
// Valid/ready channel interfaces for requests in and results out.
// Depends on edc_pkg for field widths.
interface edc_req_if;
    logic                          valid;
    logic                          ready;
    logic                          opcode;
    logic [edc_pkg::FLOOR_W-1:0]   from_floor;
    logic [edc_pkg::FLOOR_W-1:0]   to_floor;
    logic [edc_pkg::KIND_W-1:0]    passenger_kind;

    modport source (output valid, opcode, from_floor, to_floor, passenger_kind, input ready);
    modport sink   (input valid, opcode, from_floor, to_floor, passenger_kind, output ready);
endinterface

interface edc_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [edc_pkg::STATUS_W-1:0]       status;
    logic [edc_pkg::CNT_W-1:0]          alighted;
    logic [edc_pkg::CNT_W-1:0]          boarded;
    logic signed [edc_pkg::DIR_W-1:0]   move_dir;
    logic [edc_pkg::FLOOR_W-1:0]        floor_now;
    logic [edc_pkg::CNT_W-1:0]          rider_total;
    logic [edc_pkg::LOAD_W-1:0]         car_load;
    logic [edc_pkg::WAIT_W-1:0]         waiting_now;
    logic [edc_pkg::SERV_W-1:0]         serviced_count;

    modport source (output valid, status, alighted, boarded, move_dir, floor_now,
                    rider_total, car_load, waiting_now, serviced_count, input ready);
    modport sink   (input valid, status, alighted, boarded, move_dir, floor_now,
                    rider_total, car_load, waiting_now, serviced_count, output ready);
endinterface

// File: rtl/edc_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module edc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// File: rtl/edc_ctrl.sv
// Sequencer for the dispatcher: decodes each item; a tick then passes through
// alight, board and move phases. Depends on edc_pkg; drives edc_dp via t_cmd.
module edc_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    output logic           o_in_ready,
    output logic           o_out_valid,
    input  logic           i_out_ready,
    input  edc_pkg::t_sts  i_sts,
    output edc_pkg::t_cmd  o_cmd
);
    typedef enum logic [2:0] {
        S_IDLE, S_DECODE, S_ALIGHT, S_ALIGHT_CHK, S_BRD_RD, S_BRD_CHK, S_MOVE, S_OUT
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    edc_pkg::t_cmd cmd;

    // next state and commands
    always_comb begin
        n_state = r_state;
        cmd     = '0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    cmd.latch = 1'b1;
                    n_state   = S_DECODE;
                end
            end
            S_DECODE: begin
                if (i_sts.op == edc_pkg::OP_REQUEST) begin
                    cmd.req = 1'b1;
                    n_state = S_OUT;
                end else if (i_sts.has_riders) begin
                    n_state = S_ALIGHT;
                end else if (i_sts.has_best) begin
                    cmd.pick = 1'b1;
                    n_state  = i_sts.best_here ? S_BRD_RD : S_MOVE;
                end else begin
                    n_state = S_OUT;
                end
            end
            S_ALIGHT: begin
                if (i_sts.alight_done) begin
                    cmd.alight_end = 1'b1;
                    n_state        = S_ALIGHT_CHK;
                end else begin
                    cmd.alight_step = 1'b1;
                end
            end
            S_ALIGHT_CHK: begin
                if (i_sts.alight_nz) begin
                    n_state = S_OUT;
                end else begin
                    cmd.rider_target = 1'b1;
                    n_state          = S_BRD_RD;
                end
            end
            // queue head address is presented; data arrives next cycle
            S_BRD_RD: begin
                n_state = i_sts.board_can ? S_BRD_CHK : S_MOVE;
            end
            S_BRD_CHK: begin
                if (i_sts.board_fit) begin
                    cmd.board_take = 1'b1;
                    n_state        = S_BRD_RD;
                end else begin
                    n_state = S_MOVE;
                end
            end
            S_MOVE: begin
                cmd.move = 1'b1;
                n_state  = S_OUT;
            end
            S_OUT: begin
                if (!r_out_valid || i_out_ready) begin
                    cmd.out_load = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
        if (cmd.out_load) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = cmd;

    // a result is never overwritten while it waits
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_ready) |-> !cmd.out_load)
        else $error("result overwritten while pending");
    // every accepted request moves the sequencer to decode
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.latch |=> (r_state == S_DECODE))
        else $error("accepted request not decoded");
    // boarding only proceeds from a checked queue head
    a_board_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_BRD_CHK) |-> ($past(r_state) == S_BRD_RD))
        else $error("boarding check without read");
endmodule

// File: rtl/edc_dp.sv
// Datapath of the dispatcher: configuration, floor queues (in RAM), rider
// slots, car state and the result register. Depends on edc_pkg and edc_ram.
module edc_dp #(
    parameter int FLOORS      = 5,
    parameter int QUEUE_DEPTH = 16,
    parameter int RIDER_SLOTS = 8
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [edc_pkg::CFG_IDX_W-1:0]     i_cfg_idx,
    input  logic [edc_pkg::CFG_DATA_W-1:0]    i_cfg_data,
    input  logic                              i_opcode,
    input  logic [edc_pkg::FLOOR_W-1:0]       i_from_floor,
    input  logic [edc_pkg::FLOOR_W-1:0]       i_to_floor,
    input  logic [edc_pkg::KIND_W-1:0]        i_passenger_kind,
    input  edc_pkg::t_cmd                     i_cmd,
    output edc_pkg::t_sts                     o_sts,
    output logic [edc_pkg::STATUS_W-1:0]      o_status,
    output logic [edc_pkg::CNT_W-1:0]         o_alighted,
    output logic [edc_pkg::CNT_W-1:0]         o_boarded,
    output logic [edc_pkg::DIR_W-1:0]         o_move_dir,
    output logic [edc_pkg::FLOOR_W-1:0]       o_floor_now,
    output logic [edc_pkg::CNT_W-1:0]         o_rider_total,
    output logic [edc_pkg::LOAD_W-1:0]        o_car_load,
    output logic [edc_pkg::WAIT_W-1:0]        o_waiting_now,
    output logic [edc_pkg::SERV_W-1:0]        o_serviced_count
);
    localparam int FW   = edc_pkg::FLOOR_W;
    localparam int LW   = edc_pkg::LOAD_W;
    localparam int DEPTH = FLOORS * QUEUE_DEPTH;
    localparam int AW   = $clog2(DEPTH);
    localparam int HW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW  = $clog2(QUEUE_DEPTH + 1);
    localparam int FIW  = $clog2(FLOORS);
    localparam int RCW  = $clog2(RIDER_SLOTS + 1);
    localparam int SW   = (RIDER_SLOTS > 1) ? $clog2(RIDER_SLOTS) : 1;
    localparam int EW   = FW + LW;

    // configuration
    logic [LW-1:0]                  r_max_load;
    logic [edc_pkg::MAXR_W-1:0]     r_max_riders;
    logic [LW-1:0]                  r_kind_wt [4];

    // latched item
    logic                r_op;
    logic [FW-1:0]       r_from, r_to;
    logic [edc_pkg::KIND_W-1:0] r_kind;

    // car and queue state
    logic [FW-1:0]       r_floor, r_target;
    logic [RCW-1:0]      r_rcount, r_i, r_k, r_n, r_b;
    logic [FW-1:0]       r_rdest [RIDER_SLOTS];
    logic [LW-1:0]       r_rwt   [RIDER_SLOTS];
    logic [LW-1:0]       r_load;
    logic [HW-1:0]       r_head  [FLOORS];
    logic [QCW-1:0]      r_qcnt  [FLOORS];
    logic [edc_pkg::WAIT_W-1:0] r_waiting;
    logic [edc_pkg::SERV_W-1:0] r_serviced;
    logic [edc_pkg::STATUS_W-1:0] r_status;
    logic [edc_pkg::DIR_W-1:0]    r_dir;

    // result register
    logic [edc_pkg::STATUS_W-1:0] r_o_status;
    logic [edc_pkg::CNT_W-1:0]    r_o_alighted, r_o_boarded, r_o_rtotal;
    logic [edc_pkg::DIR_W-1:0]    r_o_dir;
    logic [FW-1:0]                r_o_floor;
    logic [LW-1:0]                r_o_load;
    logic [edc_pkg::WAIT_W-1:0]   r_o_waiting;
    logic [edc_pkg::SERV_W-1:0]   r_o_serviced;

    // request checks and enqueue address
    logic           req_bad, req_full, req_ok;
    logic [FIW-1:0] req_f;
    logic [AW-1:0]  waddr;
    logic [EW-1:0]  wdata;
    logic [LW-1:0]  kind_wt;
    int             tail;

    always_comb begin
        req_bad = (r_from == '0) || (int'(r_from) > FLOORS) ||
                  (r_to == '0) || (int'(r_to) > FLOORS) || (int'(r_kind) > 3);
        req_f   = FIW'(r_from - FW'(1));
        req_full = (int'(r_qcnt[req_f]) >= QUEUE_DEPTH);
        req_ok   = !req_bad && !req_full;
        tail     = int'(r_head[req_f]) + int'(r_qcnt[req_f]);
        if (tail >= QUEUE_DEPTH) begin
            tail = tail - QUEUE_DEPTH;
        end
        waddr   = AW'(int'(req_f) * QUEUE_DEPTH + tail);
        kind_wt = r_kind_wt[r_kind[1:0]];
        wdata   = {r_to, kind_wt};
    end

    // boarding read at the current floor's queue head
    logic [FIW-1:0]  car_f;
    logic [AW-1:0]   raddr;
    logic [EW-1:0]   rdata;
    logic [FW-1:0]   rd_dest;
    logic [LW-1:0]   rd_wt;
    logic [RCW-1:0]  limit;
    logic            board_can, board_fit;

    always_comb begin
        car_f   = FIW'(r_floor - FW'(1));
        raddr   = AW'(int'(car_f) * QUEUE_DEPTH + int'(r_head[car_f]));
        rd_dest = rdata[EW-1:LW];
        rd_wt   = rdata[LW-1:0];
        limit   = (int'(r_max_riders) > RIDER_SLOTS) ? RCW'(RIDER_SLOTS)
                                                    : RCW'(r_max_riders);
        board_can = (r_qcnt[car_f] != '0) && (r_rcount < limit);
        board_fit = ({1'b0, r_load} + {1'b0, rd_wt}) <= {1'b0, r_max_load};
    end

    edc_ram #(.WIDTH(EW), .DEPTH(DEPTH)) u_queue_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.req && req_ok),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    // nearest nonempty floor, lower floor wins a tie
    logic [FW-1:0] best_f, fl, span, best_d;
    logic          found;
    always_comb begin
        found  = 1'b0;
        best_f = r_floor;
        best_d = '1;
        for (int i = 0; i < FLOORS; i++) begin
            fl   = FW'(i + 1);
            span = (fl > r_floor) ? fl - r_floor : r_floor - fl;
            if ((r_qcnt[i] != '0) && (!found || span < best_d)) begin
                found  = 1'b1;
                best_d = span;
                best_f = fl;
            end
        end
    end

    // alight scan: one rider slot per cycle
    logic [SW-1:0] ai, ak;
    logic          leaves;
    always_comb begin
        ai     = r_i[SW-1:0];
        ak     = r_k[SW-1:0];
        leaves = (r_rdest[ai] == r_floor);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_load   <= edc_pkg::RST_MAX_LOAD;
            r_max_riders <= edc_pkg::RST_MAX_RIDERS;
            r_kind_wt[0] <= edc_pkg::RST_KIND0_WT;
            r_kind_wt[1] <= edc_pkg::RST_KIND1_WT;
            r_kind_wt[2] <= edc_pkg::RST_KIND2_WT;
            r_kind_wt[3] <= edc_pkg::RST_KIND3_WT;
            r_floor      <= FW'(1);
            r_rcount     <= '0;
            r_load       <= '0;
            r_waiting    <= '0;
            r_serviced   <= '0;
            for (int f = 0; f < FLOORS; f++) begin
                r_head[f] <= '0;
                r_qcnt[f] <= '0;
            end
        end else begin
            // configuration writes
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    edc_pkg::CFG_MAX_LOAD:   r_max_load   <= i_cfg_data;
                    edc_pkg::CFG_MAX_RIDERS: r_max_riders <= i_cfg_data[edc_pkg::MAXR_W-1:0];
                    edc_pkg::CFG_KIND0_WT:   r_kind_wt[0] <= i_cfg_data;
                    edc_pkg::CFG_KIND1_WT:   r_kind_wt[1] <= i_cfg_data;
                    edc_pkg::CFG_KIND2_WT:   r_kind_wt[2] <= i_cfg_data;
                    edc_pkg::CFG_KIND3_WT:   r_kind_wt[3] <= i_cfg_data;
                    default: ;
                endcase
            end
            // enqueue
            if (i_cmd.req && req_ok) begin
                r_qcnt[req_f] <= r_qcnt[req_f] + QCW'(1);
                r_waiting     <= r_waiting + edc_pkg::WAIT_W'(1);
            end
            // alight
            if (i_cmd.alight_step && leaves) begin
                r_load <= r_load - r_rwt[ai];
            end
            if (i_cmd.alight_end) begin
                r_rcount   <= r_k;
                r_serviced <= r_serviced + edc_pkg::SERV_W'(r_n);
            end
            // board
            if (i_cmd.board_take) begin
                r_rcount       <= r_rcount + RCW'(1);
                r_load         <= r_load + rd_wt;
                r_qcnt[car_f]  <= r_qcnt[car_f] - QCW'(1);
                r_waiting      <= r_waiting - edc_pkg::WAIT_W'(1);
                if (int'(r_head[car_f]) == QUEUE_DEPTH - 1) begin
                    r_head[car_f] <= '0;
                end else begin
                    r_head[car_f] <= r_head[car_f] + HW'(1);
                end
            end
            // move
            if (i_cmd.move) begin
                if (r_target > r_floor) begin
                    r_floor <= r_floor + FW'(1);
                end else if (r_target < r_floor) begin
                    r_floor <= r_floor - FW'(1);
                end
            end
        end
    end

    // payload and per-step scratch registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_op     <= i_opcode;
            r_from   <= i_from_floor;
            r_to     <= i_to_floor;
            r_kind   <= i_passenger_kind;
            r_i      <= '0;
            r_k      <= '0;
            r_n      <= '0;
            r_b      <= '0;
            r_status <= edc_pkg::ST_OK;
            r_dir    <= edc_pkg::DIR_NONE;
            r_target <= r_floor;
        end
        if (i_cmd.req) begin
            r_status <= req_bad ? edc_pkg::ST_INVALID :
                        req_full ? edc_pkg::ST_FULL : edc_pkg::ST_OK;
        end
        if (i_cmd.alight_step) begin
            r_i <= r_i + RCW'(1);
            if (leaves) begin
                r_n <= r_n + RCW'(1);
            end else begin
                r_rdest[ak] <= r_rdest[ai];
                r_rwt[ak]   <= r_rwt[ai];
                r_k         <= r_k + RCW'(1);
            end
        end
        if (i_cmd.pick) begin
            r_target <= best_f;
        end
        if (i_cmd.rider_target) begin
            r_target <= r_rdest[0];
        end
        if (i_cmd.board_take) begin
            r_rdest[r_rcount[SW-1:0]] <= rd_dest;
            r_rwt[r_rcount[SW-1:0]]   <= rd_wt;
            r_b <= r_b + RCW'(1);
        end
        if (i_cmd.move) begin
            if (r_target > r_floor) begin
                r_dir <= edc_pkg::DIR_UP;
            end else if (r_target < r_floor) begin
                r_dir <= edc_pkg::DIR_DOWN;
            end
        end
        if (i_cmd.out_load) begin
            r_o_status   <= r_status;
            r_o_alighted <= edc_pkg::CNT_W'(r_n);
            r_o_boarded  <= edc_pkg::CNT_W'(r_b);
            r_o_dir      <= r_dir;
            r_o_floor    <= r_floor;
            r_o_rtotal   <= edc_pkg::CNT_W'(r_rcount);
            r_o_load     <= r_load;
            r_o_waiting  <= r_waiting;
            r_o_serviced <= r_serviced;
        end
    end

    always_comb begin
        o_sts.op          = r_op;
        o_sts.has_riders  = (r_rcount != '0);
        o_sts.alight_done = (r_i == r_rcount);
        o_sts.alight_nz   = (r_n != '0);
        o_sts.has_best    = found;
        o_sts.best_here   = (best_f == r_floor);
        o_sts.board_can   = board_can;
        o_sts.board_fit   = board_fit;
    end

    assign o_status         = r_o_status;
    assign o_alighted       = r_o_alighted;
    assign o_boarded        = r_o_boarded;
    assign o_move_dir       = r_o_dir;
    assign o_floor_now      = r_o_floor;
    assign o_rider_total    = r_o_rtotal;
    assign o_car_load       = r_o_load;
    assign o_waiting_now    = r_o_waiting;
    assign o_serviced_count = r_o_serviced;

    // the car holds no more riders than it has slots
    a_rider_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_rcount) <= RIDER_SLOTS)
        else $error("rider count beyond slots");
    // the car never leaves the building
    a_floor_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_floor != '0) && (int'(r_floor) <= FLOORS))
        else $error("car floor out of range");
    // boarding keeps the load within the limit
    a_load_limit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.board_take |=> (r_load <= r_max_load))
        else $error("load above limit after boarding");
endmodule

// File: rtl/elevator_dispatch_controller.sv
// Top level of the single-car elevator dispatcher.
// Depends on edc_pkg, edc_if, edc_ram, edc_ctrl and edc_dp.

// Requests enter on i_req, one result leaves on o_rsp for each of them.
// One item is worked at a time. A passenger request is only checked and
// enqueued. A tick with an empty car and no waiters only reports; a tick
// with an empty car moves toward the nearest floor with waiters or, when it
// is there, boards waiters first. Each waiter is read from the queue RAM
// through its registered port before it boards, and boarding stops when the
// load limit would be exceeded after a read. With riders aboard the alight
// scan examines each rider slot in turn: a tick where someone leaves ends
// there; when nobody leaves, the car heads for the first rider's destination,
// boards waiters and moves one floor. A finished result waits in the output
// register while the next request is accepted; the following result then
// stalls until it is taken. Configuration writes are taken at any edge with
// i_cfg_we and must only be issued while no request is in progress.
module elevator_dispatch_controller #(
    parameter int FLOORS      = 5,
    parameter int QUEUE_DEPTH = 16,
    parameter int RIDER_SLOTS = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [edc_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [edc_pkg::CFG_DATA_W-1:0] i_cfg_data,
    edc_req_if.sink                        i_req,
    edc_rsp_if.source                      o_rsp
);
    edc_pkg::t_cmd cmd;
    edc_pkg::t_sts sts;

    edc_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    edc_dp #(
        .FLOORS      (FLOORS),
        .QUEUE_DEPTH (QUEUE_DEPTH),
        .RIDER_SLOTS (RIDER_SLOTS)
    ) u_dp (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_idx        (i_cfg_idx),
        .i_cfg_data       (i_cfg_data),
        .i_opcode         (i_req.opcode),
        .i_from_floor     (i_req.from_floor),
        .i_to_floor       (i_req.to_floor),
        .i_passenger_kind (i_req.passenger_kind),
        .i_cmd            (cmd),
        .o_sts            (sts),
        .o_status         (o_rsp.status),
        .o_alighted       (o_rsp.alighted),
        .o_boarded        (o_rsp.boarded),
        .o_move_dir       (o_rsp.move_dir),
        .o_floor_now      (o_rsp.floor_now),
        .o_rider_total    (o_rsp.rider_total),
        .o_car_load       (o_rsp.car_load),
        .o_waiting_now    (o_rsp.waiting_now),
        .o_serviced_count (o_rsp.serviced_count)
    );
endmodule
